@@ hdl/rational_add_subtract_reduce_defines.svh @@
// Assertion macros shared by the rational add/subtract design.
`ifndef RATIONAL_ADD_SUBTRACT_REDUCE_DEFINES_SVH
`define RATIONAL_ADD_SUBTRACT_REDUCE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define RASR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define RASR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/rasr_pkg.sv @@
// Types and status codes for the rational add/subtract block.
package rasr_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_BADDEN = 2'd1;
	localparam status_t ST_OVF    = 2'd2;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_SUB = 1'b1;

	localparam int FIELD_BITS = 32;
	localparam int DEN_BITS   = 31;

	typedef logic signed [FIELD_BITS-1:0] field_t;
	typedef logic [DEN_BITS-1:0]          den_t;

endpackage

@@ hdl/rasr_req_if.sv @@
// Request channel: operation and the two fractions.
interface rasr_req_if import rasr_pkg::*;;
	logic   valid;
	logic   ready;
	logic   command;
	field_t a_num;
	field_t a_den;
	field_t b_num;
	field_t b_den;

	modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
	modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ hdl/rasr_rsp_if.sv @@
// Response channel: reduced fraction, status and field match flag.
interface rasr_rsp_if import rasr_pkg::*;;
	logic    valid;
	logic    ready;
	field_t  res_num;
	den_t    res_den;
	status_t status;
	logic    same;

	modport source (output valid, res_num, res_den, status, same, input ready);
	modport sink   (input valid, res_num, res_den, status, same, output ready);
endinterface

@@ hdl/rasr_gcd.sv @@
// Pipelined binary greatest common divisor, one reduction step per stage.
module rasr_gcd #(
	parameter int N  = 31,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [N-1:0]  x,
	input  logic [N-1:0]  y,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [N-1:0]  g,
	output logic [SW-1:0] out_side
);

	// Every active step shortens one operand by at least a bit.
	localparam int STEPS = 2 * N;
	localparam int KW    = $clog2(N + 1);

	logic [N-1:0]  x_s    [0:STEPS];
	logic [N-1:0]  y_s    [0:STEPS];
	logic [KW-1:0] k_s    [0:STEPS];
	logic [SW-1:0] side_s [0:STEPS];
	logic          v_s    [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x;
			y_s[0]    <= y;
			k_s[0]    <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [N-1:0]  nx;
		logic [N-1:0]  ny;
		logic [KW-1:0] nk;

		always_comb begin
			nx = x_s[i];
			ny = y_s[i];
			nk = k_s[i];
			if (x_s[i] != '0 && y_s[i] != '0) begin
				if (!x_s[i][0] && !y_s[i][0]) begin
					nx = x_s[i] >> 1;
					ny = y_s[i] >> 1;
					nk = k_s[i] + KW'(1);
				end else if (!x_s[i][0]) begin
					nx = x_s[i] >> 1;
				end else if (!y_s[i][0]) begin
					ny = y_s[i] >> 1;
				end else if (x_s[i] >= y_s[i]) begin
					nx = (x_s[i] - y_s[i]) >> 1;
				end else begin
					ny = (y_s[i] - x_s[i]) >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]    <= nx;
				y_s[i+1]    <= ny;
				k_s[i+1]    <= nk;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[STEPS];
		end
	end

	// One operand is zero by now, so the other carries the odd part.
	always_ff @(posedge clk) begin
		if (en) begin
			g        <= (x_s[STEPS] | y_s[STEPS]) << k_s[STEPS];
			out_side <= side_s[STEPS];
		end
	end

endmodule

@@ hdl/rasr_div.sv @@
// Pipelined restoring divider: two dividends over one divisor, a quotient bit per stage.
module rasr_div #(
	parameter int NN = 31,
	parameter int ND = 31,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NN-1:0] a,
	input  logic [NN-1:0] b,
	input  logic [ND-1:0] d,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [NN-1:0] qa,
	output logic [NN-1:0] qb,
	output logic [SW-1:0] out_side
);

	logic [NN-1:0] na_s   [0:NN];
	logic [NN-1:0] nb_s   [0:NN];
	logic [ND-1:0] ra_s   [0:NN];
	logic [ND-1:0] rb_s   [0:NN];
	logic [ND-1:0] d_s    [0:NN];
	logic [SW-1:0] side_s [0:NN];
	logic          v_s    [0:NN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s[0]   <= a;
			nb_s[0]   <= b;
			ra_s[0]   <= '0;
			rb_s[0]   <= '0;
			d_s[0]    <= d;
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < NN; i++) begin : g_step
		logic [ND:0]   ta;
		logic [ND:0]   tb;
		logic          qa_bit;
		logic          qb_bit;
		logic [ND-1:0] nra;
		logic [ND-1:0] nrb;

		// The dividend word shifts left while quotient bits fill in from below.
		always_comb begin
			ta     = {ra_s[i], na_s[i][NN-1]};
			tb     = {rb_s[i], nb_s[i][NN-1]};
			qa_bit = (ta >= {1'b0, d_s[i]});
			qb_bit = (tb >= {1'b0, d_s[i]});
			nra    = qa_bit ? ND'(ta - {1'b0, d_s[i]}) : ta[ND-1:0];
			nrb    = qb_bit ? ND'(tb - {1'b0, d_s[i]}) : tb[ND-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				na_s[i+1]   <= {na_s[i][NN-2:0], qa_bit};
				nb_s[i+1]   <= {nb_s[i][NN-2:0], qb_bit};
				ra_s[i+1]   <= nra;
				rb_s[i+1]   <= nrb;
				d_s[i+1]    <= d_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = v_s[NN];
	assign qa        = na_s[NN];
	assign qb        = nb_s[NN];
	assign out_side  = side_s[NN];

endmodule

@@ hdl/rational_add_subtract_reduce.sv @@
// Top level of the pipelined rational add/subtract and reduce block.
//
// A request transaction on req carries a command (add or subtract) and two
// signed fractions; each rsp transaction returns the reduced sum or difference
// with a positive denominator, a status code and a flag telling whether the
// two fractions matched field for field. Operands use the low WORD_BITS bits
// of each field, sign-extended. A zero result comes back as 0/1, and a
// nonpositive denominator or a result beyond the word gives zeros with status.
// The datapath is one long pipeline: a binary GCD of the denominators, an
// exact divider for the scale factors, the multipliers and the add, a second
// binary GCD over the wide sum, and a divider for the reduction.
// One transaction is accepted per cycle while rsp is taken or holds no result. When the
// receiver stalls with a result waiting, the whole pipeline holds and req.ready
// drops; nothing is lost or repeated. Reset empties every stage.
`include "rational_add_subtract_reduce_defines.svh"

module rational_add_subtract_reduce import rasr_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	rasr_req_if.sink    req,
	rasr_rsp_if.source  rsp
);

	localparam int W  = WORD_BITS;
	localparam int D  = W - 1;
	localparam int PW = W + D + 1;
	localparam int MW = W + D;
	localparam int LW = 2 * D;
	localparam logic [MW-1:0] LIM = MW'(1) << (W - 1);

	typedef struct packed {
		logic         bad;
		logic         same;
		logic         cmd;
		logic [W-1:0] an;
		logic [W-1:0] bn;
		logic [D-1:0] ad;
		logic [D-1:0] bd;
	} g1_side_t;

	typedef struct packed {
		logic         bad;
		logic         same;
		logic         cmd;
		logic [W-1:0] an;
		logic [W-1:0] bn;
		logic [D-1:0] bd;
	} d1_side_t;

	typedef struct packed {
		logic          neg;
		logic          bad;
		logic          same;
		logic [MW-1:0] mag;
		logic [LW-1:0] lcm;
	} g2_side_t;

	typedef struct packed {
		logic neg;
		logic bad;
		logic same;
	} d2_side_t;

	logic en;

	// Input stage
	logic         v_s1;
	g1_side_t     in_s1;
	logic [W-1:0] an_w;
	logic [W-1:0] ad_w;
	logic [W-1:0] bn_w;
	logic [W-1:0] bd_w;
	logic         bad_c;

	// GCD of the denominators
	logic         g1_v;
	logic [D-1:0] g1_g;
	g1_side_t     g1_side;

	// Scale factors
	logic         d1_v;
	logic [D-1:0] fa_d;
	logic [D-1:0] fb_d;
	d1_side_t     d1_side;

	// Products
	logic                 v_s2;
	logic signed [PW-1:0] ta_s2;
	logic signed [PW-1:0] tb_s2;
	logic [LW-1:0]        lcm_s2;
	logic                 cmd_s2;
	logic                 bad_s2;
	logic                 same_s2;

	// Sum
	logic                 v_s3;
	logic signed [PW-1:0] sum_s3;
	logic [LW-1:0]        lcm_s3;
	logic                 bad_s3;
	logic                 same_s3;
	logic [MW-1:0]        mag_c;
	g2_side_t             g2_in;

	// GCD of the result
	logic          g2_v;
	logic [MW-1:0] g2_g;
	g2_side_t      g2_side;

	// Reduction
	logic          d2_v;
	logic [MW-1:0] m2_d;
	logic [MW-1:0] rd_d;
	d2_side_t      d2_side;

	// Output register
	logic    v_s4;
	field_t  num_s4;
	den_t    den_s4;
	status_t st_s4;
	logic    same_s4;
	logic    ovf_c;
	logic [W-1:0] rn_c;

	assign en        = !v_s4 || rsp.ready;
	assign req.ready = en;

	assign an_w  = req.a_num[W-1:0];
	assign ad_w  = req.a_den[W-1:0];
	assign bn_w  = req.b_num[W-1:0];
	assign bd_w  = req.b_den[W-1:0];
	assign bad_c = ad_w[W-1] || (ad_w == '0) || bd_w[W-1] || (bd_w == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid && req.ready;
		end
	end

	// If either denominator is bad, both are replaced by one so the arithmetic stays harmless.
	always_ff @(posedge clk) begin
		if (en) begin
			in_s1.bad  <= bad_c;
			in_s1.same <= (an_w == bn_w) && (ad_w == bd_w);
			in_s1.cmd  <= req.command;
			in_s1.an   <= an_w;
			in_s1.bn   <= bn_w;
			in_s1.ad   <= bad_c ? D'(1) : ad_w[D-1:0];
			in_s1.bd   <= bad_c ? D'(1) : bd_w[D-1:0];
		end
	end

	rasr_gcd #(
		.N  (D),
		.SW ($bits(g1_side_t))
	) u_gcd_den (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.x         (in_s1.ad),
		.y         (in_s1.bd),
		.in_side   (in_s1),
		.out_valid (g1_v),
		.g         (g1_g),
		.out_side  (g1_side)
	);

	d1_side_t d1_in;
	assign d1_in = '{bad: g1_side.bad, same: g1_side.same, cmd: g1_side.cmd,
		an: g1_side.an, bn: g1_side.bn, bd: g1_side.bd};

	rasr_div #(
		.NN (D),
		.ND (D),
		.SW ($bits(d1_side_t))
	) u_div_den (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (g1_v),
		.a         (g1_side.bd),
		.b         (g1_side.ad),
		.d         (g1_g),
		.in_side   (d1_in),
		.out_valid (d1_v),
		.qa        (fa_d),
		.qb        (fb_d),
		.out_side  (d1_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= d1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s2   <= $signed(d1_side.an) * $signed({1'b0, fa_d});
			tb_s2   <= $signed(d1_side.bn) * $signed({1'b0, fb_d});
			lcm_s2  <= fb_d * d1_side.bd;
			cmd_s2  <= d1_side.cmd;
			bad_s2  <= d1_side.bad;
			same_s2 <= d1_side.same;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= (cmd_s2 == CMD_SUB) ? (ta_s2 - tb_s2) : (ta_s2 + tb_s2);
			lcm_s3  <= lcm_s2;
			bad_s3  <= bad_s2;
			same_s3 <= same_s2;
		end
	end

	// A zero sum gives gcd = lcm, which reduces naturally to 0/1.
	assign mag_c = sum_s3[PW-1] ? MW'(-sum_s3) : MW'(sum_s3);
	assign g2_in = '{neg: sum_s3[PW-1], bad: bad_s3, same: same_s3,
		mag: mag_c, lcm: lcm_s3};

	rasr_gcd #(
		.N  (MW),
		.SW ($bits(g2_side_t))
	) u_gcd_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.x         (mag_c),
		.y         (MW'(lcm_s3)),
		.in_side   (g2_in),
		.out_valid (g2_v),
		.g         (g2_g),
		.out_side  (g2_side)
	);

	d2_side_t d2_in;
	assign d2_in = '{neg: g2_side.neg, bad: g2_side.bad, same: g2_side.same};

	rasr_div #(
		.NN (MW),
		.ND (MW),
		.SW ($bits(d2_side_t))
	) u_div_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (g2_v),
		.a         (g2_side.mag),
		.b         (MW'(g2_side.lcm)),
		.d         (g2_g),
		.in_side   (d2_in),
		.out_valid (d2_v),
		.qa        (m2_d),
		.qb        (rd_d),
		.out_side  (d2_side)
	);

	// The most negative word is representable, its positive twin is not.
	assign ovf_c = (m2_d > LIM) || (!d2_side.neg && m2_d == LIM) || (rd_d >= LIM);
	assign rn_c  = d2_side.neg ? W'(-m2_d) : W'(m2_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= d2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			same_s4 <= d2_side.same;
			if (d2_side.bad) begin
				st_s4  <= ST_BADDEN;
				num_s4 <= '0;
				den_s4 <= '0;
			end else if (ovf_c) begin
				st_s4  <= ST_OVF;
				num_s4 <= '0;
				den_s4 <= '0;
			end else begin
				st_s4  <= ST_OK;
				num_s4 <= FIELD_BITS'($signed(rn_c));
				den_s4 <= DEN_BITS'(rd_d[D-1:0]);
			end
		end
	end

	assign rsp.valid   = v_s4;
	assign rsp.res_num = num_s4;
	assign rsp.res_den = den_s4;
	assign rsp.status  = st_s4;
	assign rsp.same    = same_s4;

	`RASR_ASSERT_IMPL(a_err_zero, rsp.valid && rsp.status != ST_OK,
		rsp.res_num == '0 && rsp.res_den == '0, "error result is not zero")
	`RASR_ASSERT_IMPL(a_ok_den, rsp.valid && rsp.status == ST_OK,
		rsp.res_den != '0, "valid result has zero denominator")
	`RASR_ASSERT_IMPL(a_zero_one, rsp.valid && rsp.status == ST_OK && rsp.res_num == '0,
		rsp.res_den == DEN_BITS'(1), "zero result is not 0/1")
	`RASR_ASSERT_NEXT(a_hold_s1, v_s1 && !en, v_s1, "input stage lost a transaction in a stall")

endmodule
